// File: design/skgs_pkg.sv
// Shared types, codes and keyframe tables for the servo gesture sequencer.
`timescale 1ns / 1ps

package skgs_pkg;

	localparam int HOLD_W  = 9;
	localparam int ANGLE_W = 8;

	localparam logic       CMD_TICK = 1'b0;
	localparam logic       CMD_PLAY = 1'b1;

	localparam logic [2:0] GEST_NONE   = 3'd0;
	localparam logic [2:0] GEST_NOD    = 3'd1;
	localparam logic [2:0] GEST_SHAKE  = 3'd2;
	localparam logic [2:0] GEST_BOUNCE = 3'd3;
	localparam logic [2:0] GEST_TILT   = 3'd4;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 8'd180;
	localparam logic [ANGLE_W-1:0] CENTER_RESET = 8'd90;

	typedef struct packed {
		logic       cmd;
		logic [2:0] gesture_id;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_deg;
		logic               gesture_done;
	} out_t;

	typedef struct packed {
		logic [2:0] active_gesture;
		logic [2:0] keyframe_index;
	} seq_state_t;

	typedef struct packed {
		logic signed [7:0] offset;
		logic [HOLD_W-1:0] hold;
	} kf_t;

	// keyframes per gesture; unknown ids have none
	function automatic logic [2:0] gesture_len(input logic [2:0] gid);
		logic [2:0] n;
		case (gid)
			GEST_NOD:    n = 3'd4;
			GEST_SHAKE:  n = 3'd5;
			GEST_BOUNCE: n = 3'd4;
			GEST_TILT:   n = 3'd2;
			default:     n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic kf_t kf_make(input int off, input int hold);
		kf_t k;
		k.offset = 8'(off);
		k.hold   = HOLD_W'(hold);
		return k;
	endfunction

	// keyframe ROM: offset in degrees, hold in ms
	function automatic kf_t kf_lookup(input logic [2:0] gid, input logic [2:0] idx);
		kf_t k;
		k = kf_make(0, 0);
		case (gid)
			GEST_NOD: begin
				case (idx)
					3'd0:    k = kf_make(0, 80);
					3'd1:    k = kf_make(25, 160);
					3'd2:    k = kf_make(-10, 160);
					3'd3:    k = kf_make(0, 120);
					default: k = kf_make(0, 0);
				endcase
			end
			GEST_SHAKE: begin
				case (idx)
					3'd0:    k = kf_make(-25, 120);
					3'd1:    k = kf_make(25, 120);
					3'd2:    k = kf_make(-20, 120);
					3'd3:    k = kf_make(20, 120);
					3'd4:    k = kf_make(0, 100);
					default: k = kf_make(0, 0);
				endcase
			end
			GEST_BOUNCE: begin
				case (idx)
					3'd0:    k = kf_make(20, 110);
					3'd1:    k = kf_make(-15, 110);
					3'd2:    k = kf_make(12, 110);
					3'd3:    k = kf_make(0, 120);
					default: k = kf_make(0, 0);
				endcase
			end
			GEST_TILT: begin
				case (idx)
					3'd0:    k = kf_make(22, 280);
					3'd1:    k = kf_make(0, 200);
					default: k = kf_make(0, 0);
				endcase
			end
			default: k = kf_make(0, 0);
		endcase
		return k;
	endfunction

	// center + offset, clamped to 0..180
	function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] center,
		input logic signed [7:0] off);
		logic signed [9:0] sum;
		logic [ANGLE_W-1:0] a;
		sum = $signed({2'b00, center}) + $signed({{2{off[7]}}, off});
		if (sum < 10'sd0) begin
			a = '0;
		end else if (sum > $signed({2'b00, ANGLE_MAX})) begin
			a = ANGLE_MAX;
		end else begin
			a = sum[ANGLE_W-1:0];
		end
		return a;
	endfunction

endpackage

// File: design/servo_keyframe_gesture_sequencer.sv
// Top level of the servo keyframe gesture sequencer.
//
//   channel  | signals                       | beat taken when
//   ---------+-------------------------------+-------------------------
//   input    | in_valid, in_ready, in_data   | in_valid && in_ready
//   output   | out_valid, out_ready, out_data| out_valid && out_ready
//   config   | cfg_we, cfg_data              | cfg_we (center angle)
//
// One command beat per cycle sustained while the output is not stalled. A beat
// is captured in the input register, then the ROM lookup, the elapsed-time
// subtract/compare and the clamp run in one pass into the result register,
// from which the result is taken on the output channel.
// Reset clears the gesture state and sets center to 90.
// A stalled output holds the input register; in_ready drops only then.
// Beats that make no result (ignored play, tick inside a hold) still retire.
`timescale 1ns / 1ps

module servo_keyframe_gesture_sequencer #(
	parameter int TIME_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  skgs_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output skgs_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_data
);
	import skgs_pkg::*;

	localparam int START_W = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;

	// input register
	in_t  in_s1;
	logic in_valid_s1;

	// sequencer state
	seq_state_t         state_q;
	logic [START_W-1:0] start_q;
	logic [7:0]         center_q;

	// result register
	out_t out_q;
	logic out_valid_q;

	seq_state_t         state_nxt;
	logic [START_W-1:0] start_nxt;
	logic               emit;
	out_t               result;
	logic               advance;

	// the stage moves whenever the result register is free or being drained
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !in_valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	skgs_step #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_step (
		.item      (in_s1),
		.center    (center_q),
		.state_cur (state_q),
		.start_cur (start_q),
		.state_nxt (state_nxt),
		.start_nxt (start_nxt),
		.emit      (emit),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RESET;
		end else if (cfg_we) begin
			center_q <= cfg_data;
		end
	end

	// state commits as the beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			start_q <= '0;
		end else if (in_valid_s1 && advance) begin
			state_q <= state_nxt;
			start_q <= start_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1 && emit) begin
			out_q <= result;
		end
	end

endmodule

// File: design/skgs_step.sv
// Combinational next-state and result logic for one command beat.
`timescale 1ns / 1ps

module skgs_step #(
	parameter int TIME_WIDTH = 32,
	localparam int START_W = (TIME_WIDTH < 32) ? TIME_WIDTH : 32
) (
	input  skgs_pkg::in_t        item,
	input  logic [7:0]           center,
	input  skgs_pkg::seq_state_t state_cur,
	input  logic [START_W-1:0]   start_cur,
	output skgs_pkg::seq_state_t state_nxt,
	output logic [START_W-1:0]   start_nxt,
	output logic                 emit,
	output skgs_pkg::out_t       result
);
	import skgs_pkg::*;

	logic [2:0]            n_play;
	logic [2:0]            n_cur;
	logic [2:0]            idx_inc;
	logic [START_W-1:0]    now_t;
	logic [TIME_WIDTH-1:0] elapsed;
	kf_t                   kf_first;
	kf_t                   kf_cur;
	kf_t                   kf_next;
	logic                  hold_open;

	assign n_play   = gesture_len(item.gesture_id);
	assign n_cur    = gesture_len(state_cur.active_gesture);
	assign idx_inc  = state_cur.keyframe_index + 3'd1;
	assign now_t    = item.now_ms[START_W-1:0];
	assign elapsed  = TIME_WIDTH'(now_t) - TIME_WIDTH'(start_cur);
	assign kf_first = kf_lookup(item.gesture_id, 3'd0);
	assign kf_cur   = kf_lookup(state_cur.active_gesture, state_cur.keyframe_index);
	assign kf_next  = kf_lookup(state_cur.active_gesture, idx_inc);
	// still inside the current keyframe's hold window
	assign hold_open = (state_cur.keyframe_index < n_cur) &&
		(elapsed < TIME_WIDTH'(kf_cur.hold));

	always_comb begin
		state_nxt = state_cur;
		start_nxt = start_cur;
		emit      = 1'b0;
		result    = '0;
		if (item.cmd == CMD_PLAY) begin
			if (item.gesture_id != GEST_NONE) begin
				state_nxt.active_gesture = item.gesture_id;
				state_nxt.keyframe_index = 3'd0;
				start_nxt                = now_t;
				if (n_play != 3'd0) begin
					emit             = 1'b1;
					result.angle_deg = clamp_angle(center, kf_first.offset);
				end
			end
		end else if (state_cur.active_gesture != GEST_NONE && n_cur != 3'd0 && !hold_open) begin
			state_nxt.keyframe_index = idx_inc;
			start_nxt                = now_t;
			emit                     = 1'b1;
			if (idx_inc >= n_cur) begin
				// past the last keyframe: recenter and stop
				state_nxt.active_gesture = GEST_NONE;
				result.angle_deg         = clamp_angle(center, 8'sd0);
				result.gesture_done      = 1'b1;
			end else begin
				result.angle_deg = clamp_angle(center, kf_next.offset);
			end
		end
	end

endmodule

// File: design/skgs_checker.sv
// Port-level checks for the servo gesture sequencer, bound to the top level.
`timescale 1ns / 1ps

module skgs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input skgs_pkg::out_t out_data
);
	import skgs_pkg::*;

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// every angle is clamped
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.angle_deg <= ANGLE_MAX)
		else $error("angle above 180");

	// input backs up only behind a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a fresh result traces back to an accepted command beat, through the input and result registers
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching command beat");

endmodule

bind servo_keyframe_gesture_sequencer skgs_checker u_skgs_checker (.*);
